@@ rtl/tcw_pkg.sv @@
package tcw_pkg;

  // Screen geometry
  localparam int unsigned ROW_WIDTH  = 80;
  localparam int unsigned ROW_COUNT  = 25;
  localparam int unsigned TAB_WIDTH  = 8;
  localparam int unsigned CELL_COUNT = ROW_WIDTH * ROW_COUNT;

  // Field widths
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned ADDR_W = 11;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned BYTE_W = 8;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'd9;

  localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(ROW_WIDTH);
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROW_COUNT - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] MOVE_END  = ADDR_W'((ROW_COUNT - 1) * ROW_WIDTH);

  // Operation codes
  typedef enum logic [1:0] {
    OP_PUT_CHAR = 2'd0,
    OP_SET_CURSOR = 2'd1,
    OP_READ_CELL = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // Linear location of a cursor position
  function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
    logic [ADDR_W-1:0] prod;
    prod = ADDR_W'(r) * ADDR_W'(ROW_WIDTH);
    return prod + ADDR_W'(c);
  endfunction

endpackage

@@ rtl/tcw_in_if.sv @@
interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_code;
  logic [7:0] colour_attr;
  logic [7:0] new_col;
  logic [7:0] new_row;
  logic [10:0] read_address;

  modport source (output valid, opcode, char_code, colour_attr, new_col, new_row,
                  read_address, input ready);
  modport sink (input valid, opcode, char_code, colour_attr, new_col, new_row,
                read_address, output ready);
  modport monitor (input valid, ready, opcode, char_code, colour_attr, new_col,
                   new_row, read_address);
endinterface

@@ rtl/tcw_out_if.sv @@
interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [10:0] cursor_location;
  logic [15:0] cell_data;

  modport source (output valid, cursor_col, cursor_row, cursor_location, cell_data,
                  input ready);
  modport sink (input valid, cursor_col, cursor_row, cursor_location, cell_data,
                output ready);
  modport monitor (input valid, ready, cursor_col, cursor_row, cursor_location,
                   cell_data);
endinterface

@@ rtl/text_console_writer.sv @@
// Text console writer: an 80 x 25 character-cell store with a cursor.
// Input channel in_i carries one command per transaction: put character
// (newline, tab or a printable byte written as attribute:character), set
// cursor (saturated to column 80 / row 24) or read one cell. Output channel
// out_o returns exactly one result per command: the cursor column, row,
// linear location, and the cell data for a read (zero otherwise).
// When a newline or a wrapping character passes the bottom row, the store
// scrolls by a copy sweep through the cell memory, which has separate read
// and write ports, with a read state and a write state per cell. in_i.ready
// is high only while the sequencer is idle, so one command is in flight at
// a time: a new command is accepted only once the last one has reached the
// output register. After reset the sequencer blanks all 2000 cells to
// 0x0F20, one cell per cycle, and in_i.ready stays low until the clear is
// done; the cursor starts at 0,0. The result sits in an output register;
// the next command is accepted while it waits. If the receiver stalls, a
// finished command holds in the final state until the output register is
// free, and nothing is dropped.
module text_console_writer (
  input  logic     clk_i,
  input  logic     rst_ni,
  tcw_in_if.sink   in_i,
  tcw_out_if.source out_o
);
  import tcw_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_EXEC   = 8'b0000_0100,
    S_SCR_RD = 8'b0000_1000,
    S_SCR_WR = 8'b0001_0000,
    S_WRITE  = 8'b0010_0000,
    S_RDWAIT = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              wr_pend_q, wr_pend_d;
  logic              ovalid_q, ovalid_d;

  // Captured command and result payload
  op_e               op_q;
  logic [BYTE_W-1:0] ch_q, attr_q, ncol_q, nrow_q;
  logic [ADDR_W-1:0] raddr_q;
  logic [CELL_W-1:0] data_q, data_d;
  logic [COL_W-1:0]  ocol_q;
  logic [ROW_W-1:0]  orow_q;
  logic [ADDR_W-1:0] oloc_q;
  logic [CELL_W-1:0] odata_q;

  // Cell memory
  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata_q;

  logic              in_fire, out_load;
  logic [ADDR_W-1:0] cur_loc;
  logic [COL_W:0]    tab_col;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == S_DONE) && (!ovalid_q || out_o.ready);
  assign cur_loc    = cell_index(row_q, col_q);
  assign tab_col    = {1'b0, col_q} + (COL_W + 1)'(TAB_WIDTH);

  // Read address: command read or scroll source row
  always_comb begin
    if (state_q == S_SCR_RD && ptr_q < MOVE_END) begin
      mem_raddr = ptr_q + ADDR_W'(ROW_WIDTH);
    end else if (state_q == S_EXEC && raddr_q <= CELL_LAST) begin
      mem_raddr = raddr_q;
    end else begin
      mem_raddr = '0;
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    col_d     = col_q;
    row_d     = row_q;
    wr_pend_d = wr_pend_q;
    data_d    = data_q;
    ovalid_d  = ovalid_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = BLANK_CELL;

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + 1'b1;
        if (ptr_q == CELL_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        data_d  = '0;
        state_d = S_DONE;
        ptr_d   = '0;
        case (op_q)
          OP_PUT_CHAR: begin
            if (ch_q == CHAR_NEWLINE) begin
              col_d     = '0;
              wr_pend_d = 1'b0;
              if (row_q == ROW_LAST) begin
                state_d = S_SCR_RD;
              end else begin
                row_d = row_q + 1'b1;
              end
            end else if (ch_q == CHAR_TAB) begin
              col_d = (tab_col > (COL_W + 1)'(ROW_WIDTH)) ? COL_MAX : tab_col[COL_W-1:0];
            end else begin
              state_d   = S_WRITE;
              wr_pend_d = 1'b1;
              if (col_q >= COL_MAX) begin
                col_d = '0;
                if (row_q == ROW_LAST) begin
                  state_d = S_SCR_RD;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end
            end
          end
          OP_SET_CURSOR: begin
            col_d = (ncol_q > BYTE_W'(ROW_WIDTH)) ? COL_MAX : ncol_q[COL_W-1:0];
            row_d = (nrow_q > BYTE_W'(ROW_COUNT - 1)) ? ROW_LAST : nrow_q[ROW_W-1:0];
          end
          OP_READ_CELL: begin
            if (raddr_q <= CELL_LAST) begin
              state_d = S_RDWAIT;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      // Scroll: read cell ptr+80, then write it to ptr; blank the last row
      S_SCR_RD: begin
        state_d = S_SCR_WR;
      end
      S_SCR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (ptr_q < MOVE_END) ? mem_rdata_q : BLANK_CELL;
        ptr_d     = ptr_q + 1'b1;
        state_d   = S_SCR_RD;
        if (ptr_q == CELL_LAST) begin
          row_d   = ROW_LAST;
          col_d   = '0;
          state_d = wr_pend_q ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = cur_loc;
        mem_wdata = {attr_q, ch_q};
        col_d     = col_q + 1'b1;
        state_d   = S_DONE;
      end
      S_RDWAIT: begin
        data_d  = mem_rdata_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      ptr_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      wr_pend_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      col_q     <= col_d;
      row_q     <= row_d;
      wr_pend_q <= wr_pend_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (in_fire) begin
      op_q    <= op_e'(in_i.opcode);
      ch_q    <= in_i.char_code;
      attr_q  <= in_i.colour_attr;
      ncol_q  <= in_i.new_col;
      nrow_q  <= in_i.new_row;
      raddr_q <= in_i.read_address;
    end
    if (out_load) begin
      ocol_q  <= col_q;
      orow_q  <= row_q;
      oloc_q  <= cur_loc;
      odata_q <= data_q;
    end
  end

  // Cell memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  assign out_o.valid           = ovalid_q;
  assign out_o.cursor_col      = ocol_q;
  assign out_o.cursor_row      = orow_q;
  assign out_o.cursor_location = oloc_q;
  assign out_o.cell_data       = odata_q;

endmodule

@@ rtl/tcw_checker.sv @@
module tcw_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [tcw_pkg::COL_W-1:0]   out_col_i,
  input logic [tcw_pkg::ROW_W-1:0]   out_row_i,
  input logic [tcw_pkg::ADDR_W-1:0]  out_loc_i,
  input logic [tcw_pkg::CELL_W-1:0]  out_data_i
);
  import tcw_pkg::*;

  // A pending result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_loc_i) && $stable(out_data_i))
    else $error("result payload changed while stalled");

  // Cursor stays on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_col_i <= COL_MAX && out_row_i <= ROW_LAST)
    else $error("cursor out of range");

  // Location agrees with column and row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_loc_i == cell_index(out_row_i, out_col_i))
    else $error("cursor location mismatch");

  // One command in flight: busy right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command accepted while busy");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_col_i  (out_o.cursor_col),
  .out_row_i  (out_o.cursor_row),
  .out_loc_i  (out_o.cursor_location),
  .out_data_i (out_o.cell_data)
);
